// ===== rtl/slqpc_pkg.sv =====
package slqpc_pkg;

  // Queue geometry
  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = $clog2(DEPTH + 1);

  // Request codes
  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_SRCH = 2'd2
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } fsm_e;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [DATA_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [DATA_WIDTH-1:0] read_value;
    logic                         found;
    logic [IDX_W-1:0]             position;
    logic [CNT_W-1:0]             odd_total;
    logic [CNT_W-1:0]             even_total;
  } rsp_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

  // Search token handed from cell to cell
  typedef struct packed {
    logic             active;
    logic             found;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] pos;
  } tok_t;

endpackage

// ===== rtl/searchable_linear_queue_parity_count_unit.sv =====
// Enqueue, dequeue and unused codes: result strobe one cycle after the accepting edge,
// and a new request may be taken at that same edge (one request per cycle).
// Search: a token walks the chain of DEPTH cells, one cell per cycle, and the result
// is registered once the token leaves the last cell; busy is high in between.
// Results cannot be stalled by the receiver. Asynchronous active-low reset empties
// the queue and clears both tallies; stored words are left as they are.
module searchable_linear_queue_parity_count_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  slqpc_pkg::req_t   req_i,
  output logic              valid_o,
  output slqpc_pkg::rsp_t   rsp_o
);

  localparam int unsigned DEPTH = slqpc_pkg::DEPTH;
  localparam int unsigned IDX_W = slqpc_pkg::IDX_W;
  localparam int unsigned CNT_W = slqpc_pkg::CNT_W;

  slqpc_pkg::fsm_e state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic             drained_q, drained_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, odd_q, odd_d, even_q, even_d;
  logic             valid_q, valid_d;
  logic             launch_q, launch_d;
  slqpc_pkg::rsp_t  rsp_q, rsp_d;
  logic signed [slqpc_pkg::DATA_WIDTH-1:0] key_q, key_d;

  logic enq_do, deq_do;
  logic signed [slqpc_pkg::DATA_WIDTH-1:0] word_w [DEPTH];
  logic            live_w [DEPTH];
  slqpc_pkg::tok_t tok_w  [DEPTH+1];

  // Controller: update positions and tallies, build the result
  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    drained_d = drained_q;
    cnt_d     = cnt_q;
    odd_d     = odd_q;
    even_d    = even_q;
    valid_d   = 1'b0;
    launch_d  = 1'b0;
    key_d     = key_q;
    rsp_d     = rsp_q;
    enq_do    = 1'b0;
    deq_do    = 1'b0;
    unique case (state_q)
      slqpc_pkg::S_IDLE: begin
        if (start) begin
          valid_d      = 1'b1;
          rsp_d        = '0;
          rsp_d.status = slqpc_pkg::ST_DONE;
          unique case (slqpc_pkg::op_e'(req_i.operation))
            slqpc_pkg::OP_ENQ: begin
              if (!drained_q && (tail_q == IDX_W'(DEPTH - 1))) begin
                rsp_d.status = slqpc_pkg::ST_FULL;
              end else begin
                enq_do = 1'b1;
                cnt_d  = cnt_q + CNT_W'(1);
                if (drained_q) begin
                  head_d    = '0;
                  tail_d    = '0;
                  drained_d = 1'b0;
                end else begin
                  tail_d = tail_q + IDX_W'(1);
                end
                if (req_i.value[0]) odd_d = odd_q + CNT_W'(1);
                else                odd_d = odd_q;
                if (!req_i.value[0]) even_d = even_q + CNT_W'(1);
              end
            end
            slqpc_pkg::OP_DEQ: begin
              if (drained_q) begin
                rsp_d.status = slqpc_pkg::ST_EMPTY;
              end else begin
                deq_do           = 1'b1;
                rsp_d.read_value = word_w[0];
                cnt_d            = cnt_q - CNT_W'(1);
                if (head_q == tail_q) begin
                  head_d    = '0;
                  tail_d    = '0;
                  drained_d = 1'b1;
                end else begin
                  head_d = head_q + IDX_W'(1);
                end
                if (word_w[0][0]) begin
                  if (odd_q != '0) odd_d = odd_q - CNT_W'(1);
                end else begin
                  if (even_q != '0) even_d = even_q - CNT_W'(1);
                end
              end
            end
            slqpc_pkg::OP_SRCH: begin
              valid_d  = 1'b0;
              launch_d = 1'b1;
              key_d    = req_i.value;
              state_d  = slqpc_pkg::S_SCAN;
            end
            default: begin
              rsp_d.status = slqpc_pkg::ST_DONE;
            end
          endcase
        end
      end
      slqpc_pkg::S_SCAN: begin
        // Token leaving the last cell carries the search outcome
        if (tok_w[DEPTH].active) begin
          valid_d        = 1'b1;
          rsp_d          = '0;
          rsp_d.status   = slqpc_pkg::ST_DONE;
          rsp_d.found    = tok_w[DEPTH].found;
          rsp_d.position = tok_w[DEPTH].pos;
          state_d        = slqpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = slqpc_pkg::S_IDLE;
      end
    endcase
    rsp_d.odd_total  = odd_d;
    rsp_d.even_total = even_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= slqpc_pkg::S_IDLE;
      head_q    <= '0;
      tail_q    <= '0;
      drained_q <= 1'b1;
      cnt_q     <= '0;
      odd_q     <= '0;
      even_q    <= '0;
      valid_q   <= 1'b0;
      launch_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      tail_q    <= tail_d;
      drained_q <= drained_d;
      cnt_q     <= cnt_d;
      odd_q     <= odd_d;
      even_q    <= even_d;
      valid_q   <= valid_d;
      launch_q  <= launch_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    key_q <= key_d;
  end

  // Inject a fresh search token into the first cell
  assign tok_w[0] = '{active: launch_q, found: 1'b0, idx: '0, pos: '0};

  // Chain of cells: front word always sits in cell 0
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    slqpc_pkg::cell_ctl_t                    ctl;
    logic signed [slqpc_pkg::DATA_WIDTH-1:0] nbr_word;
    logic                                    nbr_live;

    assign ctl.shift = deq_do;
    assign ctl.load  = enq_do && (cnt_q[IDX_W-1:0] == IDX_W'(k));

    if (k == DEPTH - 1) begin : g_last
      assign nbr_word = '0;
      assign nbr_live = 1'b0;
    end else begin : g_mid
      assign nbr_word = word_w[k+1];
      assign nbr_live = live_w[k+1];
    end

    slqpc_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .wr_data_i  (req_i.value),
      .key_i      (key_q),
      .nbr_word_i (nbr_word),
      .nbr_live_i (nbr_live),
      .tok_i      (tok_w[k]),
      .word_o     (word_w[k]),
      .live_o     (live_w[k]),
      .tok_o      (tok_w[k+1])
    );
  end

  assign busy    = (state_q == slqpc_pkg::S_SCAN);
  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ===== rtl/slqpc_cell.sv =====
module slqpc_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  slqpc_pkg::cell_ctl_t                 ctl_i,
  input  logic signed [slqpc_pkg::DATA_WIDTH-1:0] wr_data_i,
  input  logic signed [slqpc_pkg::DATA_WIDTH-1:0] key_i,
  input  logic signed [slqpc_pkg::DATA_WIDTH-1:0] nbr_word_i,
  input  logic                                 nbr_live_i,
  input  slqpc_pkg::tok_t                      tok_i,
  output logic signed [slqpc_pkg::DATA_WIDTH-1:0] word_o,
  output logic                                 live_o,
  output slqpc_pkg::tok_t                      tok_o
);

  logic signed [slqpc_pkg::DATA_WIDTH-1:0] word_q, word_d;
  logic                                    live_q, live_d;
  slqpc_pkg::tok_t                         tok_q, tok_d;
  logic                                    hit;

  // Load on enqueue, otherwise take the neighbor's word on dequeue
  always_comb begin
    word_d = word_q;
    live_d = live_q;
    if (ctl_i.load) begin
      word_d = wr_data_i;
      live_d = 1'b1;
    end else if (ctl_i.shift) begin
      word_d = nbr_word_i;
      live_d = nbr_live_i;
    end
  end

  // Mark the first match and pass the token on
  assign hit = tok_i.active && !tok_i.found && live_q && (word_q == key_i);

  always_comb begin
    tok_d        = tok_i;
    tok_d.idx    = tok_i.idx + {{(slqpc_pkg::IDX_W-1){1'b0}}, 1'b1};
    if (hit) begin
      tok_d.found = 1'b1;
      tok_d.pos   = tok_i.idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      tok_q  <= '0;
    end else begin
      live_q <= live_d;
      tok_q  <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign live_o = live_q;
  assign tok_o  = tok_q;

endmodule

// ===== rtl/slqpc_checker.sv =====
module slqpc_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input slqpc_pkg::req_t req_i,
  input logic            valid_o,
  input slqpc_pkg::rsp_t rsp_o
);

  // Non-search beat answers on the next cycle
  a_quick_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation != slqpc_pkg::OP_SRCH)) |=> (valid_o && !busy))
    else $error("missing result for non-search beat");

  // Search beat raises busy
  a_scan_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.operation == slqpc_pkg::OP_SRCH)) |=> (busy && !valid_o))
    else $error("search did not start a scan");

  // No result while a scan is in flight
  a_no_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o)
    else $error("result during scan");

  // Empty rejection reports an empty queue
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (rsp_o.status == slqpc_pkg::ST_EMPTY)) |->
      ((rsp_o.odd_total == '0) && (rsp_o.even_total == '0) && (rsp_o.read_value == '0)))
    else $error("empty rejection with nonzero fields");

  // Tallies never exceed the store size
  a_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (({1'b0, rsp_o.odd_total} + {1'b0, rsp_o.even_total})
                 <= (slqpc_pkg::CNT_W + 1)'(slqpc_pkg::DEPTH)))
    else $error("tallies exceed depth");

endmodule

bind searchable_linear_queue_parity_count_unit slqpc_checker u_slqpc_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .req_i   (req_i),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);
